// File: hdl/npcs_pkg.sv
// Shared types, constants and the component scaling table for the nearest
// palette colour search. No dependencies.
package npcs_pkg;

  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned ADDR_W = $clog2(PALETTE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned LIM_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int unsigned EIDX_W = 8;
  localparam int unsigned IDX_W  = (ADDR_W > EIDX_W) ? ADDR_W : EIDX_W;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned LVL_W  = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    CFG_RED_MAX   = 2'd0,
    CFG_GREEN_MAX = 2'd1,
    CFG_BLUE_MAX  = 2'd2,
    CFG_PAL_SIZE  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  // travels alongside a palette word through the scan pipeline
  typedef struct packed {
    logic              vld;
    logic              usable;
    logic [ADDR_W-1:0] idx;
  } tag_t;

  // v*65535/lvl_max truncated, v clamped to lvl_max; zero max gives zero
  function automatic logic [COMP_W-1:0] scale_comp(input logic [LVL_W-1:0] v,
                                                   input logic [LVL_W-1:0] lvl_max);
    logic [LVL_W-1:0]  vc;
    logic [COMP_W-1:0] r;
    vc = (v > lvl_max) ? lvl_max : v;
    case ({lvl_max, vc})
      6'o11: r = 16'd65535;
      6'o21: r = 16'd32767;
      6'o22: r = 16'd65535;
      6'o31: r = 16'd21845;
      6'o32: r = 16'd43690;
      6'o33: r = 16'd65535;
      6'o41: r = 16'd16383;
      6'o42: r = 16'd32767;
      6'o43: r = 16'd49151;
      6'o44: r = 16'd65535;
      6'o51: r = 16'd13107;
      6'o52: r = 16'd26214;
      6'o53: r = 16'd39321;
      6'o54: r = 16'd52428;
      6'o55: r = 16'd65535;
      6'o61: r = 16'd10922;
      6'o62: r = 16'd21845;
      6'o63: r = 16'd32767;
      6'o64: r = 16'd43690;
      6'o65: r = 16'd54612;
      6'o66: r = 16'd65535;
      6'o71: r = 16'd9362;
      6'o72: r = 16'd18724;
      6'o73: r = 16'd28086;
      6'o74: r = 16'd37448;
      6'o75: r = 16'd46810;
      6'o76: r = 16'd56172;
      6'o77: r = 16'd65535;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/npcs_pal_mem.sv
// Palette store: colour words in a memory with a write port and one registered
// read port, usable marks in flops cleared by reset. Depends on npcs_pkg.
module npcs_pal_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [npcs_pkg::ADDR_W-1:0] wr_addr_i,
  input  npcs_pkg::rgb_t             wr_data_i,
  input  logic                       wr_usable_i,
  input  logic [npcs_pkg::ADDR_W-1:0] rd_addr_i,
  output npcs_pkg::rgb_t             rd_data_o,
  output logic                       rd_usable_o
);
  import npcs_pkg::*;

  rgb_t                     mem_q [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] usable_q;
  rgb_t                     rd_data_q;
  logic                     rd_usable_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // colour words of never-written slots are don't-care: they are never usable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q    <= '0;
      rd_usable_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        usable_q[wr_addr_i] <= wr_usable_i;
      end
      rd_usable_q <= usable_q[rd_addr_i];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign rd_usable_o = rd_usable_q;

endmodule

// File: hdl/npcs_dist.sv
// Shared distance unit: sum of absolute component differences, registered.
// Depends on npcs_pkg.
module npcs_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  npcs_pkg::rgb_t              entry_i,
  input  npcs_pkg::rgb_t              query_i,
  input  npcs_pkg::tag_t              tag_i,
  output npcs_pkg::tag_t              tag_o,
  output logic [npcs_pkg::DIST_W-1:0] dist_o
);
  import npcs_pkg::*;

  logic [COMP_W-1:0] dr, dg, db;
  logic [DIST_W-1:0] dist_d, dist_q;
  tag_t              tag_q;

  always_comb begin
    dr = (entry_i.red   > query_i.red)   ? entry_i.red   - query_i.red
                                         : query_i.red   - entry_i.red;
    dg = (entry_i.green > query_i.green) ? entry_i.green - query_i.green
                                         : query_i.green - entry_i.green;
    db = (entry_i.blue  > query_i.blue)  ? entry_i.blue  - query_i.blue
                                         : query_i.blue  - entry_i.blue;
    dist_d = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign tag_o  = tag_q;
  assign dist_o = dist_q;

endmodule

// File: hdl/npcs_best.sv
// Running minimum over the scan: keeps first index of least distance.
// Depends on npcs_pkg.
module npcs_best (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  npcs_pkg::tag_t              tag_i,
  input  logic [npcs_pkg::DIST_W-1:0] dist_i,
  output logic                        found_o,
  output logic [npcs_pkg::ADDR_W-1:0] best_idx_o,
  output logic [npcs_pkg::DIST_W-1:0] best_dist_o
);
  import npcs_pkg::*;

  logic              found_q;
  logic [ADDR_W-1:0] best_idx_q;
  logic [DIST_W-1:0] best_dist_q;
  logic              take;

  // strict less-than so ties keep the lower index
  assign take = tag_i.vld && tag_i.usable && (!found_q || (dist_i < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (clear_i) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_dist_q <= '0;
    end else if (take) begin
      found_q     <= 1'b1;
      best_idx_q  <= tag_i.idx;
      best_dist_q <= dist_i;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_dist_o = best_dist_q;

endmodule

// File: hdl/nearest_palette_colour_search_top.sv
// Top level of the nearest palette colour search: config registers, scan
// sequencer and result register. Depends on npcs_pkg, npcs_pal_mem,
// npcs_dist and npcs_best.
//
//   port group   dir   handshake                 payload
//   in           in    in_valid_i / in_stall_o   action, entry_*, query_*
//   out          out   out_valid_o / out_stall_i nearest_index, best_distance, none_found
//   cfg          in    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// A load is taken without leaving the idle state. A query scans L entries,
// L = min(palette_size, PALETTE_DEPTH), then drains the pipeline; with L zero
// the scan is skipped. The palette memory has one read port, so the scan reads
// one entry per cycle. The done state waits further while the previous result
// is still stalled in the output register.
// Reset clears every usable mark at once; no clearing pass.
// in_stall_o is high while a query is in progress; a finished result waits
// in the output register and the next word is taken meanwhile.
module nearest_palette_colour_search_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [7:0]                  entry_index_i,
  input  logic [15:0]                 entry_red_i,
  input  logic [15:0]                 entry_green_i,
  input  logic [15:0]                 entry_blue_i,
  input  logic                        entry_usable_i,
  input  logic [2:0]                  query_red_i,
  input  logic [2:0]                  query_green_i,
  input  logic [2:0]                  query_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  nearest_index_o,
  output logic [17:0]                 best_distance_o,
  output logic                        none_found_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [npcs_pkg::SIZE_W-1:0] cfg_wdata_i
);
  import npcs_pkg::*;

  // configuration
  logic [LVL_W-1:0]  red_max_q, green_max_q, blue_max_q;
  logic [SIZE_W-1:0] pal_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_max_q   <= 3'd7;
      green_max_q <= 3'd7;
      blue_max_q  <= 3'd3;
      pal_size_q  <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RED_MAX:   red_max_q   <= cfg_wdata_i[LVL_W-1:0];
        CFG_GREEN_MAX: green_max_q <= cfg_wdata_i[LVL_W-1:0];
        CFG_BLUE_MAX:  blue_max_q  <= cfg_wdata_i[LVL_W-1:0];
        CFG_PAL_SIZE:  pal_size_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, lim_q, lim_d, cnt_inc;
  rgb_t              qry_q, qry_d;
  logic              issue_vld_q, issue_vld_d;
  logic [ADDR_W-1:0] issue_idx_q;
  logic              clear_best, load_out;
  logic              in_accept;
  logic              wr_en;
  logic [IDX_W-1:0]  eidx_ext;
  logic [LIM_W-1:0]  size_ext;
  logic [CNT_W-1:0]  lim_new;
  logic [ADDR_W-1:0] rd_addr;

  rgb_t              rd_data, wr_data;
  logic              rd_usable;
  tag_t              tag1, tag2;
  logic [DIST_W-1:0] scan_dist;
  logic              found;
  logic [ADDR_W-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_none_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign eidx_ext = IDX_W'(entry_index_i);
  assign wr_en    = in_accept && (action_e'(action_i) == ACT_LOAD)
                 && ({1'b0, eidx_ext} < (IDX_W+1)'(PALETTE_DEPTH));
  assign wr_data  = '{red: entry_red_i, green: entry_green_i, blue: entry_blue_i};

  assign size_ext = LIM_W'(pal_size_q);
  assign lim_new  = (size_ext > LIM_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
                                                       : CNT_W'(size_ext);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign rd_addr  = cnt_q[ADDR_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    qry_d       = qry_q;
    issue_vld_d = 1'b0;
    clear_best  = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (action_e'(action_i) == ACT_QUERY)) begin
          cnt_d      = '0;
          lim_d      = lim_new;
          clear_best = 1'b1;
          qry_d      = '{red:   scale_comp(query_red_i,   red_max_q),
                         green: scale_comp(query_green_i, green_max_q),
                         blue:  scale_comp(query_blue_i,  blue_max_q)};
          state_d    = (lim_new == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        issue_vld_d = 1'b1;
        cnt_d       = cnt_inc;
        if (cnt_inc == lim_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!issue_vld_q && !tag2.vld) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lim_q       <= '0;
      issue_vld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      issue_vld_q <= issue_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q       <= qry_d;
    issue_idx_q <= rd_addr;
  end

  npcs_pal_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (eidx_ext[ADDR_W-1:0]),
    .wr_data_i   (wr_data),
    .wr_usable_i (entry_usable_i),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .rd_usable_o (rd_usable)
  );

  assign tag1 = '{vld: issue_vld_q, usable: rd_usable, idx: issue_idx_q};

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (rd_data),
    .query_i (qry_q),
    .tag_i   (tag1),
    .tag_o   (tag2),
    .dist_o  (scan_dist)
  );

  npcs_best u_best (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear_best),
    .tag_i       (tag2),
    .dist_i      (scan_dist),
    .found_o     (found),
    .best_idx_o  (best_idx),
    .best_dist_o (best_dist)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_idx_q  <= IDX_W'(best_idx);
      out_dist_q <= best_dist;
      out_none_q <= !found;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_idx_q[7:0];
  assign best_distance_o = out_dist_q;
  assign none_found_o    = out_none_q;

  // an empty search reports index and distance of zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && none_found_o |-> (nearest_index_o == '0) && (best_distance_o == '0))
    else $error("none found but index or distance non-zero");

  // reads are issued only by the scan state
  a_issue_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_vld_q |-> $past(state_q == S_SCAN))
    else $error("palette read issued outside scan");

  // the result is taken only once the pipeline has emptied
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (!issue_vld_q && !tag1.vld && !tag2.vld))
    else $error("result taken with scan words still in flight");

  // the scan address stays below the limit
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q < lim_q))
    else $error("scan counter beyond palette limit");

endmodule

// File: tb/sv/tb_nearest_palette_colour_search_top.sv
`timescale 1ns / 1ps
// Testbench for nearest_palette_colour_search_top: loads palettes, queries
// nearest colours and checks every result against an in-bench palette model.
// Depends on npcs_pkg and the top level only.
module tb_nearest_palette_colour_search_top;
  import npcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam rgb_t WHITE = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
  localparam rgb_t BLACK = '{16'h0000, 16'h0000, 16'h0000};

  typedef struct packed {
    action_e     act;
    logic [7:0]  idx;
    rgb_t        rgb;
    logic        usable;
    logic [2:0]  qr;
    logic [2:0]  qg;
    logic [2:0]  qb;
  } palette_word_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [17:0] distance;
    logic        none;
  } nearest_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall_o;
  action_e            action;
  logic [7:0]         entry_index;
  logic [15:0]        entry_red;
  logic [15:0]        entry_green;
  logic [15:0]        entry_blue;
  logic               entry_usable;
  logic [2:0]         query_red;
  logic [2:0]         query_green;
  logic [2:0]         query_blue;
  logic               out_valid_o;
  logic               out_stall;
  logic [7:0]         nearest_index_o;
  logic [17:0]        best_distance_o;
  logic               none_found_o;
  logic               cfg_we;
  cfg_idx_e           cfg_index;
  logic [SIZE_W-1:0]  cfg_wdata;

  nearest_palette_colour_search_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .action_i        (action),
    .entry_index_i   (entry_index),
    .entry_red_i     (entry_red),
    .entry_green_i   (entry_green),
    .entry_blue_i    (entry_blue),
    .entry_usable_i  (entry_usable),
    .query_red_i     (query_red),
    .query_green_i   (query_green),
    .query_blue_i    (query_blue),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .nearest_index_o (nearest_index_o),
    .best_distance_o (best_distance_o),
    .none_found_o    (none_found_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  // palette and register copy, updated as words and writes are taken
  logic [15:0]   pal_red   [PALETTE_DEPTH];
  logic [15:0]   pal_green [PALETTE_DEPTH];
  logic [15:0]   pal_blue  [PALETTE_DEPTH];
  bit            pal_use   [PALETTE_DEPTH];
  logic [2:0]    lvl_red = 3'd7;
  logic [2:0]    lvl_green = 3'd7;
  logic [2:0]    lvl_blue = 3'd3;
  logic [8:0]    pal_size = 9'd256;

  palette_word_t word_q[$];
  nearest_t      nearest_q[$];
  rgb_t          recent_rgb[$];
  palette_word_t cur_word;
  nearest_t      want;
  bit            in_took;
  bit            out_took;
  bit            tx_burst;
  bit            rx_burst;
  int unsigned   tx_gap;
  int unsigned   rx_hold;
  int unsigned   mismatches;
  int unsigned   cycle_cnt;

  initial begin
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      pal_red[i] = '0;
      pal_green[i] = '0;
      pal_blue[i] = '0;
      pal_use[i] = 1'b0;
    end
  end

  function automatic int unsigned full_scale(input logic [2:0] v, input logic [2:0] lmax);
    int unsigned vc;
    if (lmax == 0) return 0;
    vc = 32'((v > lmax) ? lmax : v);
    return (vc * 65535) / 32'(lmax);
  endfunction

  function automatic int unsigned comp_gap(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic nearest_t find_nearest(input logic [2:0] qr, input logic [2:0] qg,
                                            input logic [2:0] qb);
    int unsigned tr, tg, tb, lim, d, i;
    nearest_t    res;
    tr = full_scale(qr, lvl_red);
    tg = full_scale(qg, lvl_green);
    tb = full_scale(qb, lvl_blue);
    lim = (32'(pal_size) > PALETTE_DEPTH) ? PALETTE_DEPTH : 32'(pal_size);
    res = '{idx: '0, distance: '0, none: 1'b1};
    for (i = 0; i < lim; i++) begin
      if (pal_use[i]) begin
        d = comp_gap(32'(pal_red[i]), tr) + comp_gap(32'(pal_green[i]), tg)
          + comp_gap(32'(pal_blue[i]), tb);
        // strict less keeps the lowest index on a tie
        if (res.none || d < 32'(res.distance)) begin
          res.none = 1'b0;
          res.distance = d[17:0];
          res.idx = i[7:0];
        end
      end
    end
    return res;
  endfunction

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
  end

  // monitor: takes words into the model, checks results
  always @(posedge clk_i) begin
    in_took = in_valid && !in_stall_o;
    out_took = out_valid_o && !out_stall;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RED_MAX:   lvl_red = cfg_wdata[2:0];
          CFG_GREEN_MAX: lvl_green = cfg_wdata[2:0];
          CFG_BLUE_MAX:  lvl_blue = cfg_wdata[2:0];
          CFG_PAL_SIZE:  pal_size = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_took) begin
        if (action == ACT_LOAD) begin
          pal_red[entry_index] = entry_red;
          pal_green[entry_index] = entry_green;
          pal_blue[entry_index] = entry_blue;
          pal_use[entry_index] = entry_usable;
        end else begin
          nearest_q.push_back(find_nearest(query_red, query_green, query_blue));
        end
      end
      if (out_took) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: unexpected result: idx %0d dist %0d none %0b", $time,
                   nearest_index_o, best_distance_o, none_found_o);
          mismatches++;
        end else begin
          want = nearest_q.pop_front();
          if (nearest_index_o !== want.idx || best_distance_o !== want.distance ||
              none_found_o !== want.none) begin
            $display("%0t: mismatch: expected idx %0d dist %0d none %0b, got idx %0d dist %0d none %0b",
                     $time, want.idx, want.distance, want.none,
                     nearest_index_o, best_distance_o, none_found_o);
            mismatches++;
          end
        end
      end
    end
  end

  // driver: one word at a time from word_q, random gaps between words
  always @(negedge clk_i) begin
    bit present;
    present = in_valid;
    if (in_valid && in_took) begin
      present = 1'b0;
      tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
    end
    if (!present && rst_ni) begin
      if (tx_gap != 0) begin
        tx_gap--;
      end else if (word_q.size() != 0) begin
        cur_word = word_q.pop_front();
        present = 1'b1;
      end
    end
    in_valid     <= present;
    action       <= cur_word.act;
    entry_index  <= cur_word.idx;
    entry_red    <= cur_word.rgb.red;
    entry_green  <= cur_word.rgb.green;
    entry_blue   <= cur_word.rgb.blue;
    entry_usable <= cur_word.usable;
    query_red    <= cur_word.qr;
    query_green  <= cur_word.qg;
    query_blue   <= cur_word.qb;
  end

  // receiver: holds each waiting result for a random number of cycles
  always @(negedge clk_i) begin
    if (out_took) begin
      rx_hold = rx_burst ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
    end
    out_stall <= (rx_hold != 0);
    if (out_valid_o && rx_hold != 0) rx_hold--;
  end

  task automatic add_load(input int unsigned idx, input rgb_t c, input bit usable);
    palette_word_t w;
    w = '{act: ACT_LOAD, idx: idx[7:0], rgb: c, usable: usable,
          qr: 3'($urandom_range(0, 7)), qg: 3'($urandom_range(0, 7)),
          qb: 3'($urandom_range(0, 7))};
    word_q.push_back(w);
    recent_rgb.push_back(c);
    if (recent_rgb.size() > 8) void'(recent_rgb.pop_front());
  endtask

  task automatic add_query(input logic [2:0] qr, input logic [2:0] qg, input logic [2:0] qb);
    palette_word_t w;
    w = '{act: ACT_QUERY, idx: 8'($urandom_range(0, 255)),
          rgb: '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535))},
          usable: 1'($urandom_range(0, 1)), qr: qr, qg: qg, qb: qb};
    word_q.push_back(w);
  endtask

  // random, on-grid (exact scaled levels) or a repeat of a recent colour
  function automatic rgb_t pick_colour();
    rgb_t        c;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      c = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535))};
    end else if (mode < 8 || recent_rgb.size() == 0) begin
      c.red   = 16'(full_scale(3'($urandom_range(0, 7)), 3'($urandom_range(1, 7))));
      c.green = 16'(full_scale(3'($urandom_range(0, 7)), 3'($urandom_range(1, 7))));
      c.blue  = 16'(full_scale(3'($urandom_range(0, 7)), 3'($urandom_range(1, 7))));
    end else begin
      c = recent_rgb[$urandom_range(0, recent_rgb.size() - 1)];
    end
    return c;
  endfunction

  task automatic fill_phase(input int unsigned n_words, input int unsigned size);
    int unsigned lim;
    int unsigned idx;
    lim = (size == 0) ? 1 : ((size > PALETTE_DEPTH) ? PALETTE_DEPTH : size);
    repeat (n_words) begin
      if ($urandom_range(0, 9) < 4) begin
        // mostly slots inside the scanned range
        idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 255);
        add_load(idx, pick_colour(), $urandom_range(0, 6) != 0);
      end else begin
        add_query(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_regs(input logic [2:0] r, input logic [2:0] g, input logic [2:0] b,
                          input logic [8:0] size);
    // junk in the unused upper bits of the level writes
    write_reg(CFG_RED_MAX, {6'($urandom), r});
    write_reg(CFG_GREEN_MAX, {6'($urandom), g});
    write_reg(CFG_BLUE_MAX, {6'($urandom), b});
    write_reg(CFG_PAL_SIZE, size);
    @(negedge clk_i) cfg_we <= 1'b0;
  endtask

  // sender pauses here until every word is sent and every result is back, then settles
  task automatic wait_idle();
    int unsigned waited;
    while (word_q.size() != 0 || in_valid) @(posedge clk_i);
    waited = 0;
    while (nearest_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (nearest_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, nearest_q.size());
      mismatches += nearest_q.size();
      nearest_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] rr, gg, bb;
    logic [8:0] sz;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_RED_MAX;
    cfg_wdata = '0;
    cur_word  = '{act: ACT_LOAD, rgb: BLACK, default: '0};
    rx_hold   = $urandom_range(0, 3);

    // directed, at reset register values (7, 7, 3, 256)
    add_query(3'd0, 3'd0, 3'd0);                       // empty palette: none found
    add_load(0, BLACK, 1'b1);
    add_load(255, WHITE, 1'b1);
    add_load(5, '{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0); // not usable, never chosen
    add_query(3'd0, 3'd0, 3'd0);
    add_query(3'd7, 3'd7, 3'd3);
    add_query(3'd7, 3'd0, 3'd3);
    add_query(3'd3, 3'd4, 3'd7);                       // blue above its max
    add_load(10, WHITE, 1'b1);                         // tie with slot 255
    add_query(3'd7, 3'd7, 3'd7);
    add_load(2, BLACK, 1'b1);                          // tie with slot 0
    add_query(3'd0, 3'd0, 3'd0);
    add_load(0, '{16'h8000, 16'h8000, 16'h8000}, 1'b0);
    add_query(3'd0, 3'd0, 3'd0);
    add_load(128, '{16'h1234, 16'hFEDC, 16'h00FF}, 1'b1);
    add_query(3'd1, 3'd6, 3'd2);
    add_query(3'd5, 3'd2, 3'd0);

    wait_idle();
    set_regs(3'd1, 3'd1, 3'd1, 9'd1);
    fill_phase(150, 1);
    wait_idle();
    set_regs(3'd0, 3'd7, 3'd0, 9'd0);                  // zero max, zero palette size
    fill_phase(150, 0);
    wait_idle();
    set_regs(3'd7, 3'd7, 3'd7, 9'd511);                // size beyond depth
    fill_phase(150, 511);
    wait_idle();
    set_regs(3'd7, 3'd0, 3'd3, 9'd256);
    fill_phase(150, 256);
    repeat (8) begin
      rr = 3'($urandom_range(0, 7));
      gg = 3'($urandom_range(0, 7));
      bb = 3'($urandom_range(0, 7));
      sz = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                       : 9'($urandom_range(1, 24));
      wait_idle();
      set_regs(rr, gg, bb, sz);
      fill_phase(150, 32'(sz));
    end
    wait_idle();

    if (mismatches == 0)
      $display("tb_nearest_palette_colour_search_top: done, clean");
    else
      $display("tb_nearest_palette_colour_search_top: done, errors");
    $finish;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout", $time);
    $display("tb_nearest_palette_colour_search_top: done, errors");
    $finish;
  end

endmodule
